// ===== hw/rtl/lsgf_pkg.sv =====
// Shared types, constants and pixel arithmetic for the LCD smoothing and ghosting filter.
package lsgf_pkg;

  localparam int unsigned FRAME_WIDTH  = 160;
  localparam int unsigned FRAME_HEIGHT = 144;
  localparam int unsigned FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
  localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT + 1);
  localparam int unsigned IDX_W = $clog2(FRAME_SIZE);

  localparam int unsigned PIX_W = 24;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Filter weights: smooth (28*c + r + d)/32, blend (7*cur + prev)/8.
  localparam logic [12:0] SMOOTH_CENTER_W = 13'd28;
  localparam logic [10:0] BLEND_CUR_W     = 11'd7;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } lsgf_mode_e;

  // One word of work handed from front to back.
  typedef struct packed {
    logic [PIX_W-1:0] color;
    logic [IDX_W-1:0] idx;
    logic             done;
  } lsgf_job_t;

  function automatic logic [PIX_W-1:0] smooth_px(input logic [PIX_W-1:0] c,
                                                 input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] res;
    logic [12:0]      sum;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      sum = 13'(c[8*k+:8]) * SMOOTH_CENTER_W + 13'(r[8*k+:8]) + 13'(d[8*k+:8]);
      res[8*k+:8] = sum[12:5];
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] cur,
                                                input logic [PIX_W-1:0] prev);
    logic [PIX_W-1:0] res;
    logic [10:0]      sum;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      sum = 11'(cur[8*k+:8]) * BLEND_CUR_W + 11'(prev[8*k+:8]);
      res[8*k+:8] = sum[10:3];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/lsgf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsgf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lsgf_front.sv =====
// Front end: accepts words, tracks frame position, line store and smoothing.
module lsgf_front import lsgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [PIX_W-1:0] color_i,
  input  logic [QCW-1:0]   q_count_i,
  output logic             push_o,
  output lsgf_job_t        job_o,
  output logic             s1_busy_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // stage 1
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic             s1_smooth_q;
  logic             s1_done_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [PIX_W-1:0] s1_below_q;

  logic [PIX_W-1:0] center_q;
  logic [PIX_W-1:0] ls_rdata;

  logic             acc, is_pix, full, work, emit, last_col, done;
  logic [COL_W-1:0] col_next;
  logic [QCW:0]     credit;

  assign credit     = {1'b0, q_count_i} + (QCW+1)'(s1_valid_q);
  assign in_ready_o = credit < (QCW+1)'(QDEPTH);
  assign acc        = in_valid_i && in_ready_o;

  assign is_pix   = (mode_i == MODE_PIXEL);
  assign full     = (row_q == ROW_W'(FRAME_HEIGHT));
  assign work     = is_pix ? !full : full;
  assign emit     = is_pix ? (row_q != '0) : 1'b1;
  assign last_col = (col_q == COL_W'(FRAME_WIDTH - 1));
  assign col_next = last_col ? '0 : col_q + COL_W'(1);
  assign done     = !is_pix && (idx_q == IDX_W'(FRAME_SIZE - 1));

  // Right neighbour read; the same data is the next word's centre.
  lsgf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (acc && is_pix && !full),
    .waddr_i (col_q),
    .wdata_i (color_i),
    .re_i    (acc && work),
    .raddr_i (col_next),
    .rdata_o (ls_rdata)
  );

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (acc && work) begin
      col_d = col_next;
      if (is_pix && last_col) begin
        row_d = row_q + ROW_W'(1);
      end
      if (emit) begin
        idx_d = done ? '0 : idx_q + IDX_W'(1);
      end
      if (done) begin
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      idx_q      <= idx_d;
      s1_valid_q <= acc && work;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && work) begin
      s1_emit_q   <= emit;
      s1_smooth_q <= is_pix && !last_col;
      s1_done_q   <= done;
      s1_idx_q    <= idx_q;
      s1_below_q  <= color_i;
    end
    if (s1_valid_q) begin
      center_q <= ls_rdata;
    end
  end

  assign push_o      = s1_valid_q && s1_emit_q;
  assign job_o.color = s1_smooth_q ? smooth_px(center_q, ls_rdata, s1_below_q) : center_q;
  assign job_o.idx   = s1_idx_q;
  assign job_o.done  = s1_done_q;
  assign s1_busy_o   = s1_valid_q;

endmodule

// ===== hw/rtl/lsgf_fifo.sv =====
// Short work queue between front end and back end.
module lsgf_fifo import lsgf_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsgf_job_t      job_i,
  input  logic           pop_i,
  output lsgf_job_t      head_o,
  output logic [QCW-1:0] count_o
);

  lsgf_job_t      mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/lsgf_back.sv =====
// Back end: previous-frame blend, write-back and output register.
module lsgf_back import lsgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [QCW-1:0]   q_count_i,
  input  lsgf_job_t        head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_color_o,
  output logic             frame_done_o
);

  logic             b1_valid_q;
  lsgf_job_t        b1_job_q;
  logic             prev_ok_q;   // a whole frame has been written back
  logic             out_valid_q;
  logic [PIX_W-1:0] out_color_q;
  logic             out_done_q;

  logic [PIX_W-1:0] pf_rdata, prev, res;
  logic             adv;

  assign adv   = b1_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o = (q_count_i != '0) && (!b1_valid_q || adv);
  assign prev  = prev_ok_q ? pf_rdata : '0;
  assign res   = blend_px(b1_job_q.color, prev);

  lsgf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_SIZE)
  ) u_prev_frame (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (b1_job_q.idx),
    .wdata_i (res),
    .re_i    (pop_o),
    .raddr_i (head_i.idx),
    .rdata_o (pf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      prev_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b1_valid_q <= 1'b1;
      end else if (adv) begin
        b1_valid_q <= 1'b0;
      end
      if (adv && b1_job_q.done) begin
        prev_ok_q <= 1'b1;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_job_q <= head_i;
    end
    if (adv) begin
      out_color_q <= res;
      out_done_q  <= b1_job_q.done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_color_o  = out_color_q;
  assign frame_done_o = out_done_q;

endmodule

// ===== hw/rtl/lcd_smooth_and_ghost_filter_unit.sv =====
// Top level of the LCD smoothing and ghosting filter.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+----------------------------
//  in      | in        | in_valid_i / in_ready_o  | mode_i, color_i
//  out     | out       | out_valid_o / out_ready_i| out_color_o, frame_done_o
//
// One word per clock sustained while the output is ready; a result passes through
// the line-store read stage, the work queue, the previous-frame read stage and the output register.
// in_ready_o drops once queue words plus the front stage fill the four-entry queue.
// Reset needs no clearing pass: the first frame blends against zero until a
// complete frame has been written back to the previous-frame store.
// A stalled output holds its register while the queue keeps taking words.
module lcd_smooth_and_ghost_filter_unit import lsgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [PIX_W-1:0] color_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] out_color_o,
  output logic             frame_done_o
);

  logic           push, pop, s1_busy;
  lsgf_job_t      job, head;
  logic [QCW-1:0] q_count;

  // Front: position tracking, drop/ignore decisions, smoothing.
  lsgf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .color_i    (color_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .job_o      (job),
    .s1_busy_o  (s1_busy)
  );

  lsgf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  // Back: temporal blend against the previous frame.
  lsgf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_count_i    (q_count),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_color_o  (out_color_o),
    .frame_done_o (frame_done_o)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count != QCW'(QDEPTH)))
    else $error("work queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0))
    else $error("work queue underflow");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_busy && (q_count == QCW'(QDEPTH - 1))) |-> !in_ready_o)
    else $error("front accepted without queue credit");
`endif

endmodule

// ===== sim/tb_lcd_smooth_and_ghost_filter_unit.sv =====
// Self-checking testbench for the LCD smoothing and ghosting filter top level.
module tb_lcd_smooth_and_ghost_filter_unit;
  import lsgf_pkg::*;

  // Run shape
  localparam int unsigned SEG_WORDS    = 250;      // words fed between drain pauses
  localparam int unsigned TAIL_PIXELS  = 1000;     // opening part of the first frame
  localparam int unsigned HOLD_AFTER   = 300;      // words taken before the long stall
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam time         RUN_LIMIT    = 10_000_000;

  typedef struct packed {
    lsgf_mode_e       mode;
    logic [PIX_W-1:0] color;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] color;
    logic             done;
  } pix_result_t;

  // DUT ports
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic             mode_i      = MODE_PIXEL;
  logic [PIX_W-1:0] color_i     = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PIX_W-1:0] out_color_o;
  logic             frame_done_o;

  // Stimulus control
  in_word_t    word_queue[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold        = 1'b0;
  logic        in_fire        = 1'b0;

  // Shadow of the filter state
  logic [PIX_W-1:0] row_buf     [FRAME_WIDTH];
  logic [PIX_W-1:0] ghost_frame [FRAME_SIZE];
  int unsigned      pix_in  = 0;
  int unsigned      pix_out = 0;

  pix_result_t expected_pixels[$];
  int unsigned words_taken  = 0;
  int unsigned mismatch_cnt = 0;

  lcd_smooth_and_ghost_filter_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .color_i      (color_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_color_o  (out_color_o),
    .frame_done_o (frame_done_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Spatial smoothing per channel: (28*centre + right + below) / 32.
  function automatic logic [PIX_W-1:0] smooth_rgb(logic [PIX_W-1:0] c,
                                                  logic [PIX_W-1:0] r,
                                                  logic [PIX_W-1:0] d);
    logic [PIX_W-1:0] res;
    int unsigned      acc;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      acc = 28 * int'(c[8*k +: 8]) + int'(r[8*k +: 8]) + int'(d[8*k +: 8]);
      res[8*k +: 8] = 8'(acc / 32);
    end
    return res;
  endfunction

  // Temporal ghosting per channel: (7*current + previous) / 8, truncating.
  function automatic logic [PIX_W-1:0] ghost_rgb(logic [PIX_W-1:0] cur,
                                                 logic [PIX_W-1:0] prev);
    logic [PIX_W-1:0] res;
    int unsigned      acc;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      acc = 7 * int'(cur[8*k +: 8]) + int'(prev[8*k +: 8]);
      res[8*k +: 8] = 8'(acc / 8);
    end
    return res;
  endfunction

  // Blend against the stored frame, write back and queue the expected pixel.
  task automatic emit_pixel(logic [PIX_W-1:0] cur, int unsigned idx, logic done);
    pix_result_t r;
    r.color          = ghost_rgb(cur, ghost_frame[idx]);
    r.done           = done;
    ghost_frame[idx] = r.color;
    expected_pixels.push_back(r);
  endtask

  // Advance the shadow state by one accepted word.
  task automatic filter_word(lsgf_mode_e mode, logic [PIX_W-1:0] color);
    int unsigned      col;
    logic [PIX_W-1:0] cur;
    if (mode == MODE_PIXEL) begin
      if (pix_in >= FRAME_SIZE) return;     // frame waiting for flush: dropped
      col = pix_in % FRAME_WIDTH;
      if (pix_in >= FRAME_WIDTH) begin
        // pixel above is now complete; last column is not smoothed
        if (col + 1 < FRAME_WIDTH)
          cur = smooth_rgb(row_buf[col], row_buf[col + 1], color);
        else
          cur = row_buf[col];
        emit_pixel(cur, pix_in - FRAME_WIDTH, 1'b0);
        pix_out++;
      end
      row_buf[col] = color;
      pix_in++;
    end else begin
      if (pix_in < FRAME_SIZE || pix_out >= FRAME_SIZE) return;  // nothing to flush
      col = pix_out % FRAME_WIDTH;
      // last row goes out unsmoothed; final pixel closes the frame
      emit_pixel(row_buf[col], pix_out, (pix_out + 1 >= FRAME_SIZE));
      pix_out++;
      if (pix_out >= FRAME_SIZE) begin
        pix_in  = 0;
        pix_out = 0;
      end
    end
  endtask

  function automatic logic [PIX_W-1:0] random_color();
    logic [PIX_W-1:0] c;
    case ($urandom_range(7))
      0:       c = '0;
      1:       c = '1;
      2: begin
        // each channel pinned to an extreme
        for (int k = 0; k < 3; k++) c[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: c = PIX_W'($urandom());
    endcase
    return c;
  endfunction

  // Driver: new words and ready change on the falling edge only.
  always @(negedge clk_i) begin : drive_proc
    in_word_t w;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = word_queue.pop_front();
          in_valid_i <= 1'b1;
          mode_i     <= w.mode;
          color_i    <= w.color;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check results, then account for the accepted input word.
  always @(posedge clk_i) begin : watch_proc
    pix_result_t want;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: unexpected word: expected none, actual color %06h done %0b",
                   $time, out_color_o, frame_done_o);
      end else begin
        want = expected_pixels.pop_front();
        if (out_color_o !== want.color) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: out_color: expected %06h, actual %06h",
                     $time, want.color, out_color_o);
        end
        if (frame_done_o !== want.done) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: frame_done: expected %0b, actual %0b",
                     $time, want.done, frame_done_o);
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      filter_word(lsgf_mode_e'(mode_i), color_i);
      words_taken++;
    end
  end

  // Long output stall while the sender keeps offering, so the queue fills
  // and in_ready_o has to drop.
  initial begin : hold_off
    while (words_taken < HOLD_AFTER) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    in_word_t         stream[$];
    in_word_t         w;
    logic [PIX_W-1:0] corner_colors[12];
    logic [PIX_W-1:0] c;
    int unsigned      seg;

    corner_colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h010101, 24'hFEFEFE,
                      24'h808080, 24'h7F7F7F};
    for (int i = 0; i < FRAME_SIZE; i++) ghost_frame[i] = '0;

    // Flush with nothing buffered: ignored.
    w.mode  = MODE_FLUSH;
    w.color = random_color();
    stream.push_back(w);

    // Opening rows of the first frame: row 0 is only stored, later rows
    // give results blended against the cleared frame store.
    for (int i = 0; i < TAIL_PIXELS; i++) begin
      if (i > 0 && $urandom_range(63) == 0) begin
        // stray flush mid-frame: ignored
        w.mode  = MODE_FLUSH;
        w.color = random_color();
        stream.push_back(w);
      end
      // opening words: extremes on row 0, mirrored below on row 1
      if (i < 12)
        c = corner_colors[i];
      else if (i >= FRAME_WIDTH && i < FRAME_WIDTH + 12)
        c = corner_colors[11 - (i - FRAME_WIDTH)];
      else
        c = random_color();
      w.mode  = MODE_PIXEL;
      w.color = c;
      stream.push_back(w);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Feed in segments; each ends with the sender paused until every
    // expected word is back, then the idling pattern moves on.
    seg = 0;
    while (stream.size() != 0) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < SEG_WORDS && stream.size() != 0; n++)
        word_queue.push_back(stream.pop_front());
      while (word_queue.size() != 0 || in_valid_i || expected_pixels.size() != 0)
        @(posedge clk_i);
      seg++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
